// ===== rtl/c8ic_pkg.sv =====
// Shared types, constants and the glyph table of the CHIP-8 instruction core.
// Used by c8ic_ctrl, c8ic_datapath and chip8_instruction_core. No dependencies.
`timescale 1ns / 1ps
package c8ic_pkg;

    localparam int ADDR_W = 12;
    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_ROWS = 32;
    localparam int SCREEN_COLS = 64;
    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int COL_W = $clog2(SCREEN_COLS);

    localparam logic [ADDR_W-1:0] PROGRAM_START = 12'h200;
    localparam logic [ADDR_W-1:0] GLYPH_BASE = 12'h050;
    localparam logic [ADDR_W-1:0] GLYPH_END = 12'h09F;
    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0] FN_STOP = 8'h00;
    localparam logic [7:0] FN_FONT = 8'h29;
    localparam logic [7:0] FN_BCD = 8'h33;
    localparam logic [7:0] FN_LOAD = 8'h65;

    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_OPCODE = 2'd1;
    localparam logic [1:0] FAULT_UNDERFLOW = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

    // Datapath actions, one per cycle.
    typedef enum logic [4:0] {
        DP_NONE,
        DP_CLR_WR,
        DP_LATCH,
        DP_HOST_WR,
        DP_HOST_RD,
        DP_HOST_CAP,
        DP_FETCH_HI,
        DP_FETCH_LO,
        DP_CAP_OP,
        DP_RD_Y,
        DP_CAP_Y,
        DP_EXEC,
        DP_FLAG,
        DP_POP,
        DP_DRAW_RD,
        DP_DRAW_WR,
        DP_BCD,
        DP_LOAD_RD,
        DP_LOAD_WR,
        DP_OUT
    } dp_op_t;

    // How an opcode is sequenced after its execute cycle.
    typedef enum logic [2:0] {
        OC_BASIC,
        OC_FLAG,
        OC_RET,
        OC_DRAW,
        OC_BCD,
        OC_LOAD
    } op_class_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic        clr_last;
        logic        halted;
        logic        sp_empty;
        logic [15:0] opcode;
        logic        draw_last;
        logic        bcd_last;
        logic        load_last;
    } dp_status_t;

    function automatic op_class_t op_class(input logic [15:0] op);
        op_class_t c;
        c = OC_BASIC;
        unique case (op[15:12])
            4'h0: if (op == OP_RET) c = OC_RET;
            4'h8: begin
                case (op[3:0]) inside
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE: c = OC_FLAG;
                    default: c = OC_BASIC;
                endcase
            end
            4'hD: c = OC_DRAW;
            4'hF: begin
                if (op[7:0] == FN_BCD) c = OC_BCD;
                else if (op[7:0] == FN_LOAD) c = OC_LOAD;
            end
            default: c = OC_BASIC;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0: b = 8'hF0;  7'd1: b = 8'h90;  7'd2: b = 8'h90;  7'd3: b = 8'h90;
            7'd4: b = 8'hF0;  7'd5: b = 8'h20;  7'd6: b = 8'h60;  7'd7: b = 8'h20;
            7'd8: b = 8'h20;  7'd9: b = 8'h70;  7'd10: b = 8'hF0; 7'd11: b = 8'h10;
            7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
            7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
            7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
            7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
            7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
            7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
            7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
            7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
            7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
            7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
            7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
            7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
            7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
            7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
            7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
            7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
            7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/c8ic_ctrl.sv =====
// Sequencing state machine of the CHIP-8 instruction core.
// Depends on c8ic_pkg; drives c8ic_datapath through dp_cmd_t.
`timescale 1ns / 1ps
module c8ic_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  c8ic_pkg::dp_status_t status,
    output c8ic_pkg::dp_cmd_t    cmd
);

    typedef enum logic [18:0] {
        ST_CLEAR    = 19'h00001,
        ST_IDLE     = 19'h00002,
        ST_HOST_WR  = 19'h00004,
        ST_HOST_RD  = 19'h00008,
        ST_HOST_CAP = 19'h00010,
        ST_FETCH_HI = 19'h00020,
        ST_FETCH_LO = 19'h00040,
        ST_CAP_OP   = 19'h00080,
        ST_RD_Y     = 19'h00100,
        ST_CAP_Y    = 19'h00200,
        ST_EXEC     = 19'h00400,
        ST_FLAG     = 19'h00800,
        ST_POP      = 19'h01000,
        ST_DRAW_RD  = 19'h02000,
        ST_DRAW_WR  = 19'h04000,
        ST_BCD      = 19'h08000,
        ST_LOAD_RD  = 19'h10000,
        ST_LOAD_WR  = 19'h20000,
        ST_DONE     = 19'h40000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.op       = c8ic_pkg::DP_NONE;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = c8ic_pkg::DP_CLR_WR;
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = c8ic_pkg::DP_LATCH;
                    if (s_mode == c8ic_pkg::MODE_EXEC) begin
                        state_next = status.halted ? ST_DONE : ST_FETCH_HI;
                    end else if (s_mode == c8ic_pkg::MODE_WRITE) begin
                        state_next = ST_HOST_WR;
                    end else begin
                        state_next = ST_HOST_RD;
                    end
                end
            end
            ST_HOST_WR: begin
                cmd.op = c8ic_pkg::DP_HOST_WR;
                state_next = ST_DONE;
            end
            ST_HOST_RD: begin
                cmd.op = c8ic_pkg::DP_HOST_RD;
                state_next = ST_HOST_CAP;
            end
            ST_HOST_CAP: begin
                cmd.op = c8ic_pkg::DP_HOST_CAP;
                state_next = ST_DONE;
            end
            ST_FETCH_HI: begin
                cmd.op = c8ic_pkg::DP_FETCH_HI;
                state_next = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                cmd.op = c8ic_pkg::DP_FETCH_LO;
                state_next = ST_CAP_OP;
            end
            ST_CAP_OP: begin
                cmd.op = c8ic_pkg::DP_CAP_OP;
                state_next = ST_RD_Y;
            end
            ST_RD_Y: begin
                cmd.op = c8ic_pkg::DP_RD_Y;
                state_next = ST_CAP_Y;
            end
            ST_CAP_Y: begin
                cmd.op = c8ic_pkg::DP_CAP_Y;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.op = c8ic_pkg::DP_EXEC;
                unique case (c8ic_pkg::op_class(status.opcode))
                    c8ic_pkg::OC_RET:  state_next = status.sp_empty ? ST_DONE : ST_POP;
                    c8ic_pkg::OC_FLAG: state_next = ST_FLAG;
                    c8ic_pkg::OC_DRAW: begin
                        state_next = (status.opcode[3:0] == 4'h0) ? ST_FLAG : ST_DRAW_RD;
                    end
                    c8ic_pkg::OC_BCD:  state_next = ST_BCD;
                    c8ic_pkg::OC_LOAD: state_next = ST_LOAD_RD;
                    default:           state_next = ST_DONE;
                endcase
            end
            ST_FLAG: begin
                cmd.op = c8ic_pkg::DP_FLAG;
                state_next = ST_DONE;
            end
            ST_POP: begin
                cmd.op = c8ic_pkg::DP_POP;
                state_next = ST_DONE;
            end
            ST_DRAW_RD: begin
                cmd.op = c8ic_pkg::DP_DRAW_RD;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                cmd.op = c8ic_pkg::DP_DRAW_WR;
                state_next = status.draw_last ? ST_FLAG : ST_DRAW_RD;
            end
            ST_BCD: begin
                cmd.op = c8ic_pkg::DP_BCD;
                if (status.bcd_last) state_next = ST_DONE;
            end
            ST_LOAD_RD: begin
                cmd.op = c8ic_pkg::DP_LOAD_RD;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                cmd.op = c8ic_pkg::DP_LOAD_WR;
                state_next = status.load_last ? ST_DONE : ST_LOAD_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op = c8ic_pkg::DP_OUT;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/c8ic_datapath.sv =====
// Datapath of the CHIP-8 instruction core: memory, registers, stack, screen, ALU.
// Depends on c8ic_pkg; commanded by c8ic_ctrl.
`timescale 1ns / 1ps
module c8ic_datapath #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  c8ic_pkg::dp_cmd_t    cmd,
    output c8ic_pkg::dp_status_t status,
    input  logic [1:0]           s_mode,
    input  logic [11:0]          s_address,
    input  logic [7:0]           s_data,
    input  logic [7:0]           s_random_byte,
    output logic [11:0]          m_pc,
    output logic                 m_halted,
    output logic                 m_collision,
    output logic [1:0]           m_fault,
    output logic [31:0]          m_read_data
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int AW = c8ic_pkg::ADDR_W;
    localparam int RW = c8ic_pkg::ROW_W;
    localparam int CW = c8ic_pkg::COL_W;
    localparam int NC = c8ic_pkg::SCREEN_COLS;

    // Memories.
    logic [7:0]    prog_mem   [c8ic_pkg::MEM_BYTES];
    logic [7:0]    vreg_mem   [16];
    logic [AW-1:0] stack_mem  [STACK_DEPTH];
    logic [NC-1:0] screen_mem [c8ic_pkg::SCREEN_ROWS];

    // Architectural state.
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic [AW-1:0] i_reg, i_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic          stop_reg, stop_next;
    logic [15:0]   vvalid_reg, vvalid_next;
    logic [c8ic_pkg::SCREEN_ROWS-1:0] svalid_reg, svalid_next;

    // Working registers.
    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    rnd_reg, rnd_next;
    logic [7:0]    hi_reg, hi_next;
    logic [15:0]   op_reg, op_next;
    logic [7:0]    vx_reg, vx_next;
    logic [7:0]    vy_reg, vy_next;
    logic          flag_reg, flag_next;
    logic          hit_reg, hit_next;
    logic [1:0]    fault_reg, fault_next;
    logic [31:0]   rd_reg, rd_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [CW-1:0] x0_reg, x0_next;
    logic [RW-1:0] y0_reg, y0_next;
    logic [AW-1:0] out_pc_reg;
    logic          out_halted_reg, out_hit_reg;
    logic [1:0]    out_fault_reg;
    logic [31:0]   out_rd_reg;

    // Registered read data.
    logic [7:0]    mem_q_reg;
    logic [7:0]    v_q_reg;
    logic          v_qv_reg;
    logic [AW-1:0] st_q_reg;
    logic [NC-1:0] sc_q_reg;
    logic          sc_qv_reg;

    // Port controls.
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;
    logic          v_we;
    logic [3:0]    v_waddr, v_raddr;
    logic [7:0]    v_wdata;
    logic          st_we;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [AW-1:0] st_wdata;
    logic          sc_we;
    logic [RW-1:0] sc_waddr, sc_raddr;
    logic [NC-1:0] sc_wdata;

    // Decode and helpers.
    logic [3:0]    op_x, op_n;
    logic [7:0]    op_nn;
    logic [AW-1:0] op_nnn, pc_plus2, pc_plus4;
    logic [7:0]    v_rd, alu_val;
    logic          alu_flag, alu_ok;
    logic [8:0]    sum9;
    logic [NC-1:0] sprite_row, draw_mask, screen_row;
    logic [2*NC-1:0] sprite_dbl;
    logic [1:0]    bcd_h;
    logic [7:0]    bcd_rem;
    logic [15:0]   bcd_prod;
    logic [3:0]    bcd_t;
    logic [7:0]    bcd_o, bcd_digit;
    logic [AW-1:0] glyph_off;

    assign op_x     = op_reg[11:8];
    assign op_n     = op_reg[3:0];
    assign op_nn    = op_reg[7:0];
    assign op_nnn   = op_reg[11:0];
    assign pc_plus2 = pc_reg + 12'd2;
    assign pc_plus4 = pc_reg + 12'd4;
    assign v_rd     = v_qv_reg ? v_q_reg : 8'h00;
    assign sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign screen_row = sc_qv_reg ? sc_q_reg : '0;
    assign sprite_row = {mem_q_reg, {(NC-8){1'b0}}};
    assign sprite_dbl = {sprite_row, sprite_row} >> x0_reg;
    assign draw_mask  = sprite_dbl[NC-1:0];
    assign glyph_off  = clr_cnt_reg - c8ic_pkg::GLYPH_BASE;

    // Decimal digits of VX: hundreds by compare, tens by reciprocal of ten.
    always_comb begin
        if (vx_reg >= 8'd200) bcd_h = 2'd2;
        else if (vx_reg >= 8'd100) bcd_h = 2'd1;
        else bcd_h = 2'd0;
        bcd_rem  = vx_reg - 8'(bcd_h) * 8'd100;
        bcd_prod = {8'h00, bcd_rem} * 16'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - {bcd_t, 3'b000} - {3'b000, bcd_t, 1'b0};
        case (cnt_reg[1:0])
            2'd0:    bcd_digit = {6'd0, bcd_h};
            2'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end

    always_comb begin
        alu_ok   = 1'b1;
        alu_flag = 1'b0;
        case (op_n)
            4'h0: alu_val = vy_reg;
            4'h1: alu_val = vx_reg | vy_reg;
            4'h2: alu_val = vx_reg & vy_reg;
            4'h3: alu_val = vx_reg ^ vy_reg;
            4'h4: begin
                alu_val  = sum9[7:0];
                alu_flag = sum9[8];
            end
            4'h5: begin
                alu_val  = vx_reg - vy_reg;
                alu_flag = vx_reg > vy_reg;
            end
            4'h6: begin
                alu_val  = {1'b0, vx_reg[7:1]};
                alu_flag = vx_reg[0];
            end
            4'h7: begin
                alu_val  = vy_reg - vx_reg;
                alu_flag = vy_reg > vx_reg;
            end
            4'hE: begin
                alu_val  = {vx_reg[6:0], 1'b0};
                alu_flag = vx_reg[7];
            end
            default: begin
                alu_val = vx_reg;
                alu_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        pc_next      = pc_reg;
        i_next       = i_reg;
        sp_next      = sp_reg;
        stop_next    = stop_reg;
        vvalid_next  = vvalid_reg;
        svalid_next  = svalid_reg;
        mode_next    = mode_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        rnd_next     = rnd_reg;
        hi_next      = hi_reg;
        op_next      = op_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        flag_next    = flag_reg;
        hit_next     = hit_reg;
        fault_next   = fault_reg;
        rd_next      = rd_reg;
        cnt_next     = cnt_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        mem_we       = 1'b0;
        mem_waddr    = i_reg + {8'h00, cnt_reg};
        mem_wdata    = bcd_digit;
        mem_raddr    = pc_reg;
        v_we         = 1'b0;
        v_waddr      = op_x;
        v_wdata      = alu_val;
        v_raddr      = op_x;
        st_we        = 1'b0;
        st_waddr     = sp_reg[SAW-1:0];
        st_wdata     = pc_plus2;
        st_raddr     = sp_reg[SAW-1:0] - 1'b1;
        sc_we        = 1'b0;
        sc_waddr     = y0_reg + {1'b0, cnt_reg};
        sc_wdata     = screen_row ^ draw_mask;
        sc_raddr     = y0_reg + {1'b0, cnt_reg};

        unique case (cmd.op)
            c8ic_pkg::DP_CLR_WR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (clr_cnt_reg >= c8ic_pkg::GLYPH_BASE && clr_cnt_reg <= c8ic_pkg::GLYPH_END) begin
                    mem_wdata = c8ic_pkg::glyph_byte(glyph_off[6:0]);
                end else begin
                    mem_wdata = 8'h00;
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            c8ic_pkg::DP_LATCH: begin
                mode_next  = s_mode;
                addr_next  = s_address;
                data_next  = s_data;
                rnd_next   = s_random_byte;
                fault_next = c8ic_pkg::FAULT_NONE;
                hit_next   = 1'b0;
                rd_next    = 32'h0;
            end
            c8ic_pkg::DP_HOST_WR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = data_reg;
            end
            c8ic_pkg::DP_HOST_RD: begin
                mem_raddr = addr_reg;
                sc_raddr  = addr_reg[RW:1];
            end
            c8ic_pkg::DP_HOST_CAP: begin
                if (!mode_reg[0]) rd_next = {24'h0, mem_q_reg};
                else if (addr_reg[0]) rd_next = screen_row[31:0];
                else rd_next = screen_row[63:32];
            end
            c8ic_pkg::DP_FETCH_HI: begin
                mem_raddr = pc_reg;
            end
            c8ic_pkg::DP_FETCH_LO: begin
                hi_next   = mem_q_reg;
                mem_raddr = pc_reg + 12'd1;
            end
            c8ic_pkg::DP_CAP_OP: begin
                op_next = {hi_reg, mem_q_reg};
                v_raddr = hi_reg[3:0];
            end
            c8ic_pkg::DP_RD_Y: begin
                vx_next = v_rd;
                v_raddr = (op_reg[15:12] == 4'hB) ? 4'h0 : op_reg[7:4];
            end
            c8ic_pkg::DP_CAP_Y: begin
                vy_next = v_rd;
            end
            c8ic_pkg::DP_EXEC: begin
                unique case (op_reg[15:12])
                    4'h0: begin
                        if (op_reg == c8ic_pkg::OP_CLS) begin
                            svalid_next = '0;
                            pc_next     = pc_plus2;
                        end else if (op_reg == c8ic_pkg::OP_RET) begin
                            if (sp_reg == '0) fault_next = c8ic_pkg::FAULT_UNDERFLOW;
                            else sp_next = sp_reg - 1'b1;
                        end else begin
                            fault_next = c8ic_pkg::FAULT_OPCODE;
                        end
                    end
                    4'h1: pc_next = op_nnn;
                    4'h2: begin
                        if (sp_reg >= SPW'(STACK_DEPTH)) begin
                            fault_next = c8ic_pkg::FAULT_OVERFLOW;
                        end else begin
                            st_we   = 1'b1;
                            sp_next = sp_reg + 1'b1;
                            pc_next = op_nnn;
                        end
                    end
                    4'h3: pc_next = (vx_reg == op_nn) ? pc_plus4 : pc_plus2;
                    4'h4: pc_next = (vx_reg != op_nn) ? pc_plus4 : pc_plus2;
                    4'h5: pc_next = (vx_reg == vy_reg) ? pc_plus4 : pc_plus2;
                    4'h6: begin
                        v_we    = 1'b1;
                        v_wdata = op_nn;
                        pc_next = pc_plus2;
                    end
                    4'h7: begin
                        v_we    = 1'b1;
                        v_wdata = vx_reg + op_nn;
                        pc_next = pc_plus2;
                    end
                    4'h8: begin
                        if (alu_ok) begin
                            v_we      = 1'b1;
                            flag_next = alu_flag;
                            pc_next   = pc_plus2;
                        end else begin
                            fault_next = c8ic_pkg::FAULT_OPCODE;
                        end
                    end
                    4'h9: begin
                        if (op_n != 4'h0) fault_next = c8ic_pkg::FAULT_OPCODE;
                        else pc_next = (vx_reg != vy_reg) ? pc_plus4 : pc_plus2;
                    end
                    4'hA: begin
                        i_next  = op_nnn;
                        pc_next = pc_plus2;
                    end
                    // VY was read from V0 for this opcode.
                    4'hB: pc_next = op_nnn + {4'h0, vy_reg};
                    4'hC: begin
                        v_we    = 1'b1;
                        v_wdata = rnd_reg & op_nn;
                        pc_next = pc_plus2;
                    end
                    4'hD: begin
                        x0_next   = vx_reg[CW-1:0];
                        y0_next   = vy_reg[RW-1:0];
                        cnt_next  = 4'h0;
                        hit_next  = 1'b0;
                        flag_next = 1'b0;
                        pc_next   = pc_plus2;
                    end
                    4'hF: begin
                        if (op_nn == c8ic_pkg::FN_STOP) begin
                            stop_next = 1'b1;
                        end else if (op_nn == c8ic_pkg::FN_FONT) begin
                            i_next  = c8ic_pkg::GLYPH_BASE + {2'b00, vx_reg, 2'b00}
                                      + {4'h0, vx_reg};
                            pc_next = pc_plus2;
                        end else if (op_nn == c8ic_pkg::FN_BCD
                                     || op_nn == c8ic_pkg::FN_LOAD) begin
                            cnt_next = 4'h0;
                            pc_next  = pc_plus2;
                        end else begin
                            fault_next = c8ic_pkg::FAULT_OPCODE;
                        end
                    end
                    default: fault_next = c8ic_pkg::FAULT_OPCODE;
                endcase
            end
            c8ic_pkg::DP_FLAG: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = {7'h00, flag_reg};
            end
            c8ic_pkg::DP_POP: begin
                pc_next = st_q_reg;
            end
            c8ic_pkg::DP_DRAW_RD: begin
                mem_raddr = i_reg + {8'h00, cnt_reg};
            end
            c8ic_pkg::DP_DRAW_WR: begin
                sc_we       = 1'b1;
                svalid_next[sc_waddr] = 1'b1;
                hit_next    = hit_reg | (|(screen_row & draw_mask));
                flag_next   = hit_next;
                cnt_next    = cnt_reg + 1'b1;
            end
            c8ic_pkg::DP_BCD: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            c8ic_pkg::DP_LOAD_RD: begin
                mem_raddr = i_reg + {8'h00, cnt_reg};
            end
            c8ic_pkg::DP_LOAD_WR: begin
                v_we     = 1'b1;
                v_waddr  = cnt_reg;
                v_wdata  = mem_q_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase

        if (v_we) vvalid_next[v_waddr] = 1'b1;
    end

    assign status.clr_last  = &clr_cnt_reg;
    assign status.halted    = stop_reg;
    assign status.sp_empty  = (sp_reg == '0);
    assign status.opcode    = op_reg;
    assign status.draw_last = (cnt_reg == op_n - 4'd1);
    assign status.bcd_last  = (cnt_reg == 4'd2);
    assign status.load_last = (cnt_reg == op_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            pc_reg      <= c8ic_pkg::PROGRAM_START;
            i_reg       <= '0;
            sp_reg      <= '0;
            stop_reg    <= 1'b0;
            vvalid_reg  <= '0;
            svalid_reg  <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
            pc_reg      <= pc_next;
            i_reg       <= i_next;
            sp_reg      <= sp_next;
            stop_reg    <= stop_next;
            vvalid_reg  <= vvalid_next;
            svalid_reg  <= svalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        rnd_reg   <= rnd_next;
        hi_reg    <= hi_next;
        op_reg    <= op_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        flag_reg  <= flag_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
        rd_reg    <= rd_next;
        cnt_reg   <= cnt_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        if (cmd.op == c8ic_pkg::DP_OUT) begin
            out_pc_reg     <= pc_reg;
            out_halted_reg <= stop_reg;
            out_hit_reg    <= hit_reg;
            out_fault_reg  <= fault_reg;
            out_rd_reg     <= rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) prog_mem[mem_waddr] <= mem_wdata;
        mem_q_reg <= prog_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) vreg_mem[v_waddr] <= v_wdata;
        v_q_reg  <= vreg_mem[v_raddr];
        v_qv_reg <= vvalid_reg[v_raddr];
    end

    always_ff @(posedge aclk) begin
        if (st_we) stack_mem[st_waddr] <= st_wdata;
        st_q_reg <= stack_mem[st_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sc_we) screen_mem[sc_waddr] <= sc_wdata;
        sc_q_reg  <= screen_mem[sc_raddr];
        sc_qv_reg <= svalid_reg[sc_raddr];
    end

    assign m_pc        = out_pc_reg;
    assign m_halted    = out_halted_reg;
    assign m_collision = out_hit_reg;
    assign m_fault     = out_fault_reg;
    assign m_read_data = out_rd_reg;

endmodule

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 instruction core, top level: controller plus datapath.
// Depends on c8ic_pkg, c8ic_ctrl and c8ic_datapath.
`timescale 1ns / 1ps
// Usage: every item on the s_ channel is one step. Mode 0 fetches and
// executes the instruction at the program counter, mode 1 writes s_data to
// memory at s_address, mode 2 reads a memory byte and mode 3 reads half a
// screen row (s_address bits 5..1 pick the row, bit 0 the half).
// Each item yields exactly one result item on the m_ channel with the
// program counter after the step, the halted flag, the collision flag, the
// fault code and the read data.
// One item is worked on at a time. Each step is sequenced through the
// single read port of the program memory and of the register file,
// which the sequencer walks one byte per access.
// After reset the core clears and preloads its memory with the font glyphs,
// one byte a cycle over all 4096 bytes, and holds s_ready low until that is done.
// Results sit in an output register: the next item is accepted while one
// waits, and when the receiver stalls the following result waits until the
// register drains.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [11:0] s_address,
    input  logic [7:0]  s_data,
    input  logic [7:0]  s_random_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pc,
    output logic        m_halted,
    output logic        m_collision,
    output logic [1:0]  m_fault,
    output logic [31:0] m_read_data
);

    // Command to the datapath and its status back to the controller.
    c8ic_pkg::dp_cmd_t    cmd;
    c8ic_pkg::dp_status_t status;

    c8ic_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    c8ic_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_address     (s_address),
        .s_data        (s_data),
        .s_random_byte (s_random_byte),
        .m_pc          (m_pc),
        .m_halted      (m_halted),
        .m_collision   (m_collision),
        .m_fault       (m_fault),
        .m_read_data   (m_read_data)
    );

endmodule
